### rtl/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef enum logic [0:0] {
    OpAbsorb = 1'b0,
    OpFinish = 1'b1
  } op_e;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StPad    = 6'b000010,
    StLoad   = 6'b000100,
    StRound  = 6'b001000,
    StUpdate = 6'b010000,
    StEmit   = 6'b100000
  } state_e;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

### rtl/sha256_if.sv
// Valid/ready stream interfaces for input beats and digest beats.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] op;
  logic [7:0] byte_value;
  modport source (output valid, op, byte_value, input ready);
  modport sink   (input valid, op, byte_value, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha256_stream_hasher.sv
// Top level: byte-stream SHA-256 hasher built around a block word memory.
//
// Input channel (sha256_in_if): each beat carries op and byte_value. op
// absorb adds one message byte; op finish pads the message, runs the final
// compression(s) and emits the digest. Output channel (sha256_out_if): eight
// beats per finish, word_index 0..7, last_word set on the eighth.
// An absorb beat is taken whenever the hasher is idle; the 64th byte of a
// block starts a compression (a load of the 16-entry word memory through
// its registered read, 64 rounds at one per cycle, one hash update),
// during which in.ready is low. A finish beat writes pad bytes from the
// fill position p to the end of the block, then compresses it; when
// p >= 56 an extra pad block follows and is compressed as well. The first
// digest beat is offered after the last hash update, then one word per
// cycle while the receiver is ready.
// A stalled receiver holds the current digest beat; no input is taken until
// all eight beats are delivered. Reset (rst_ni low, asynchronous) returns the
// hash to the initial values and clears the length count; block memory
// content is undefined until written and needs no clearing pass.
module sha256_stream_hasher (
  input logic clk_i,
  input logic rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  sha256_pkg::state_e state_q, state_d;

  logic [63:0] bitlen_q, bitlen_d;
  logic [63:0] flen_q, flen_d;    // length latched at finish
  logic [5:0]  pos_q, pos_d;      // padding write position
  logic        final_q, final_d;  // compression is the last of a finish
  logic        fin_q, fin_d;      // finish in progress
  logic [6:0]  cnt_q, cnt_d;      // round / load counter
  logic [2:0]  emit_q, emit_d;
  sha256_pkg::word_t h_q [8];
  sha256_pkg::word_t h_d [8];
  sha256_pkg::word_t v_q [8];
  sha256_pkg::word_t v_d [8];
  sha256_pkg::word_t rv  [8];
  sha256_pkg::word_t win_q [16];  // schedule window, shift line
  sha256_pkg::word_t win_d [16];
  sha256_pkg::word_t w_new, w_cur;
  logic [31:0] part_q, part_d;    // assembles bytes into words

  // block word memory
  logic        we;
  logic [3:0]  waddr, raddr;
  sha256_pkg::word_t wdata, rdata;

  sha256_ram #(.Width(32), .Depth(16)) u_blk (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // schedule expansion from the window
  assign w_new = sha256_pkg::ssig1(win_q[14]) + win_q[9] +
                 sha256_pkg::ssig0(win_q[1]) + win_q[0];
  assign w_cur = (cnt_q < 7'd16) ? win_q[cnt_q[3:0]] : w_new;

  sha256_round u_round (
    .v_i(v_q), .w_i(w_cur), .k_i(sha256_pkg::RoundK[cnt_q[5:0]]), .v_o(rv)
  );

  logic [5:0] bpos;
  assign bpos = bitlen_q[8:3];

  // pad byte at the current padding position
  logic [7:0] pad_byte;
  always_comb begin
    if (pos_q >= sha256_pkg::LenPos && final_q) begin
      pad_byte = flen_q[6'd63 - {pos_q[2:0], 3'd0} -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    bitlen_d = bitlen_q;
    flen_d = flen_q;
    pos_d = pos_q;
    final_d = final_q;
    fin_d = fin_q;
    cnt_d = cnt_q;
    emit_d = emit_q;
    h_d = h_q;
    v_d = v_q;
    win_d = win_q;
    part_d = part_q;
    we = 1'b0;
    waddr = 4'd0;
    wdata = '0;
    raddr = cnt_q[3:0];
    in_i.ready = 1'b0;
    case (state_q)
      sha256_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.op == sha256_pkg::OpAbsorb) begin
            part_d = {part_q[23:0], in_i.byte_value};
            bitlen_d = bitlen_q + 64'd8;
            if (bpos[1:0] == 2'd3) begin
              we = 1'b1;
              waddr = bpos[5:2];
              wdata = {part_q[23:0], in_i.byte_value};
            end
            if (bpos == 6'd63) begin
              final_d = 1'b0;
              cnt_d = '0;
              state_d = sha256_pkg::StLoad;
            end
          end else begin
            flen_d = bitlen_q;
            fin_d = 1'b1;
            part_d = {part_q[23:0], sha256_pkg::PadByte};
            if (bpos[1:0] == 2'd3) begin
              we = 1'b1;
              waddr = bpos[5:2];
              wdata = {part_q[23:0], sha256_pkg::PadByte};
            end
            pos_d = bpos + 6'd1;
            final_d = (bpos < 6'd56);
            state_d = (bpos == 6'd63) ? sha256_pkg::StLoad : sha256_pkg::StPad;
            cnt_d = '0;
          end
        end
      end
      // one padding byte per cycle until the block is full
      sha256_pkg::StPad: begin
        part_d = {part_q[23:0], pad_byte};
        if (pos_q[1:0] == 2'd3) begin
          we = 1'b1;
          waddr = pos_q[5:2];
          wdata = {part_q[23:0], pad_byte};
        end
        pos_d = pos_q + 6'd1;
        if (pos_q == 6'd63) begin
          cnt_d = '0;
          state_d = sha256_pkg::StLoad;
        end
      end
      // read 16 words into the window; the registered read returns each word in the cycle after its address
      sha256_pkg::StLoad: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q != 7'd0) begin
          win_d[cnt_q[3:0] - 4'd1] = rdata;
        end
        if (cnt_q == 7'd16) begin
          cnt_d = '0;
          v_d = h_q;
          state_d = sha256_pkg::StRound;
        end
      end
      sha256_pkg::StRound: begin
        v_d = rv;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q >= 7'd16) begin
          for (int i = 0; i < 15; i++) win_d[i] = win_q[i+1];
          win_d[15] = w_new;
        end
        if (cnt_q == 7'd63) begin
          state_d = sha256_pkg::StUpdate;
        end
      end
      sha256_pkg::StUpdate: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        if (final_q) begin
          emit_d = '0;
          state_d = sha256_pkg::StEmit;
        end else if (fin_q) begin
          // extra padding block of a finish
          final_d = 1'b1;
          pos_d = 6'd0;
          state_d = sha256_pkg::StPad;
        end else begin
          state_d = sha256_pkg::StIdle;
        end
      end
      sha256_pkg::StEmit: begin
        if (out_o.ready) begin
          emit_d = emit_q + 3'd1;
          if (emit_q == 3'd7) begin
            h_d = sha256_pkg::InitH;
            bitlen_d = '0;
            fin_d = 1'b0;
            state_d = sha256_pkg::StIdle;
          end
        end
      end
      default: state_d = sha256_pkg::StIdle;
    endcase
  end

  assign out_o.valid       = (state_q == sha256_pkg::StEmit);
  assign out_o.digest_word = h_q[emit_q];
  assign out_o.word_index  = emit_q;
  assign out_o.last_word   = (emit_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha256_pkg::StIdle;
      bitlen_q <= '0;
      h_q      <= sha256_pkg::InitH;
      cnt_q    <= '0;
      emit_q   <= '0;
      final_q  <= 1'b0;
      fin_q    <= 1'b0;
      pos_q    <= '0;
      flen_q   <= '1;
    end else begin
      state_q  <= state_d;
      bitlen_q <= bitlen_d;
      h_q      <= h_d;
      cnt_q    <= cnt_d;
      emit_q   <= emit_d;
      final_q  <= final_d;
      fin_q    <= fin_d;
      pos_q    <= pos_d;
      flen_q   <= flen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    win_q  <= win_d;
    part_q <= part_d;
  end

`ifndef SYNTHESIS
  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sha256_pkg::StIdle) |-> !in_i.ready)
    else $error("input taken while busy");
  a_emit_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q) == sha256_pkg::StUpdate)
    else $error("digest emitted without compression");
  a_emit_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> out_o.word_index == 3'd0)
    else $error("digest does not start at word zero");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256_pkg::StRound) |-> cnt_q < 7'd64)
    else $error("round counter overrun");
`endif

endmodule

### rtl/sha256_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sha256_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/sha256_round.sv
// One SHA-256 round on the working variables plus the schedule word sum.
module sha256_round (
  input  sha256_pkg::word_t v_i [8],
  input  sha256_pkg::word_t w_i,
  input  sha256_pkg::word_t k_i,
  output sha256_pkg::word_t v_o [8]
);

  sha256_pkg::word_t t1, t2, ch, maj;

  always_comb begin
    ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1  = v_i[7] + sha256_pkg::bsig1(v_i[4]) + ch + k_i + w_i;
    t2  = sha256_pkg::bsig0(v_i[0]) + maj;
    v_o[0] = t1 + t2;
    v_o[1] = v_i[0];
    v_o[2] = v_i[1];
    v_o[3] = v_i[2];
    v_o[4] = v_i[3] + t1;
    v_o[5] = v_i[4];
    v_o[6] = v_i[5];
    v_o[7] = v_i[6];
  end

endmodule
